>>> sv/cpdc_pkg.sv
package cpdc_pkg;

   localparam int HEADER_BYTES = 20;
   localparam int COUNT_W      = 34;
   localparam int WORD_W       = 32;
   localparam int QUEUE_DEPTH  = 2;

   // header word boundaries, in bytes
   localparam int CHECKSUM_OFS = 4;
   localparam int STREAM_OFS   = 8;
   localparam int MSGWORD_OFS  = 12;
   localparam int LENGTH_OFS   = 16;

   localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;

   typedef logic [2:0] status_type;
   localparam status_type STATUS_OK       = 3'd0;
   localparam status_type STATUS_SHORT    = 3'd1;
   localparam status_type STATUS_BAD_MAGIC = 3'd2;
   localparam status_type STATUS_BAD_TERM = 3'd3;
   localparam status_type STATUS_BAD_CRC  = 3'd4;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_MAGIC     = 2'd0;
   localparam csr_index_type CSR_TERMINATOR = 2'd1;
   localparam csr_index_type CSR_REPLY_POS = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0] magic_word;
      logic [7:0]        terminator_byte;
      logic [4:0]        reply_bit_pos;
   } cfg_type;

   // one finished request result on its way to the back end
   typedef struct packed {
      logic              kind;
      logic [7:0]        data;
      status_type        status;
      logic [WORD_W-1:0] stream;
      logic [WORD_W-1:0] msgword;
      logic [WORD_W-1:0] length;
   } entry_type;

   function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                  input logic [7:0] b);
      logic [WORD_W-1:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> sv/cpdc_if.sv
interface cpdc_req_if;
   import cpdc_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface cpdc_rsp_if;
   import cpdc_pkg::*;
   logic              valid;
   logic              ready;
   logic              out_kind;
   logic [7:0]        out_byte;
   logic [2:0]        out_status;
   logic [WORD_W-1:0] out_stream_id;
   logic [WORD_W-1:0] out_message_id;
   logic              out_is_reply;
   logic [WORD_W-1:0] out_payload_len;
   logic              out_last;
   modport source (output valid, output out_kind, output out_byte, output out_status,
                   output out_stream_id, output out_message_id, output out_is_reply,
                   output out_payload_len, output out_last, input ready);
   modport sink   (input valid, input out_kind, input out_byte, input out_status,
                   input out_stream_id, input out_message_id, input out_is_reply,
                   input out_payload_len, input out_last, output ready);
endinterface

interface cpdc_csr_if;
   import cpdc_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        index;
   logic [WORD_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/cpdc_front.sv
module cpdc_front (
   input  logic               clock,
   input  logic               reset,
   cpdc_req_if.sink           req_bus,
   input  cpdc_pkg::cfg_type  cfg,
   input  logic               q_ready,
   output logic               q_push,
   output cpdc_pkg::entry_type q_entry
);
   import cpdc_pkg::*;

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [WORD_W-1:0]  crc_ff, crc_in;
   logic [WORD_W-1:0]  magic_ff, magic_in;
   logic [WORD_W-1:0]  checksum_ff, checksum_in;
   logic [WORD_W-1:0]  stream_ff, stream_in;
   logic [WORD_W-1:0]  msgword_ff, msgword_in;
   logic [WORD_W-1:0]  length_ff, length_in;
   logic               term_good_ff, term_good_in;

   logic               accept;
   logic [7:0]         b;
   logic               in_header;
   logic               in_payload;
   logic               at_term;
   logic [COUNT_W-1:0] pay_end;
   logic [WORD_W-1:0]  hdr_new;
   logic               magic_ok;
   logic               emit;
   status_type         status;

   assign req_bus.ready = q_ready;
   assign accept        = req_bus.valid && q_ready;
   assign b             = req_bus.in_byte;

   always_comb begin
      in_header   = byte_count_ff < COUNT_W'(HEADER_BYTES);
      hdr_new     = '0;
      magic_in    = magic_ff;
      checksum_in = checksum_ff;
      stream_in   = stream_ff;
      msgword_in  = msgword_ff;
      length_in   = length_ff;
      if (in_header) begin
         if (byte_count_ff < COUNT_W'(CHECKSUM_OFS)) begin
            magic_in = {magic_ff[WORD_W-9:0], b};
         end else if (byte_count_ff < COUNT_W'(STREAM_OFS)) begin
            checksum_in = {checksum_ff[WORD_W-9:0], b};
         end else if (byte_count_ff < COUNT_W'(MSGWORD_OFS)) begin
            stream_in = {stream_ff[WORD_W-9:0], b};
         end else if (byte_count_ff < COUNT_W'(LENGTH_OFS)) begin
            msgword_in = {msgword_ff[WORD_W-9:0], b};
         end else begin
            length_in = {length_ff[WORD_W-9:0], b};
         end
      end
      pay_end    = COUNT_W'(HEADER_BYTES) + COUNT_W'(length_in);
      in_payload = !in_header && (byte_count_ff < pay_end);
      at_term    = !in_header && (byte_count_ff == pay_end);

      // checksum bytes enter the CRC as zero
      crc_in = crc_ff;
      if (in_header) begin
         if (byte_count_ff >= COUNT_W'(CHECKSUM_OFS) && byte_count_ff < COUNT_W'(STREAM_OFS)) begin
            crc_in = crc_byte(crc_ff, 8'd0);
         end else begin
            crc_in = crc_byte(crc_ff, b);
         end
      end else if (in_payload) begin
         crc_in = crc_byte(crc_ff, b);
      end

      term_good_in = at_term ? (b == cfg.terminator_byte) : term_good_ff;
      magic_ok     = magic_in == cfg.magic_word;
      emit         = in_payload && magic_ok;

      // first failure wins; a last byte inside the payload reads as truncated unless the magic is bad
      if (byte_count_ff < COUNT_W'(HEADER_BYTES - 1)) begin
         status = STATUS_SHORT;
      end else if (!magic_ok) begin
         status = STATUS_BAD_MAGIC;
      end else if (byte_count_ff < pay_end) begin
         status = STATUS_SHORT;
      end else if (!term_good_in) begin
         status = STATUS_BAD_TERM;
      end else if (~crc_in != checksum_in) begin
         status = STATUS_BAD_CRC;
      end else begin
         status = STATUS_OK;
      end

      q_push          = accept && (req_bus.in_last || emit);
      q_entry         = '0;
      q_entry.data    = hdr_new[7:0];
      if (req_bus.in_last) begin
         q_entry.kind   = KIND_STATUS;
         q_entry.status = status;
         if (status != STATUS_SHORT || byte_count_ff >= COUNT_W'(HEADER_BYTES - 1)) begin
            q_entry.stream  = stream_in;
            q_entry.msgword = msgword_in;
            q_entry.length  = length_in;
         end
      end else begin
         q_entry.kind = KIND_PAYLOAD;
         q_entry.data = b;
      end

      byte_count_in = (byte_count_ff == '1) ? byte_count_ff : byte_count_ff + COUNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         crc_ff        <= '1;
         magic_ff      <= '0;
         checksum_ff   <= '0;
         stream_ff     <= '0;
         msgword_ff    <= '0;
         length_ff     <= '0;
         term_good_ff  <= 1'b0;
      end else if (accept) begin
         if (req_bus.in_last) begin
            byte_count_ff <= '0;
            crc_ff        <= '1;
            magic_ff      <= '0;
            checksum_ff   <= '0;
            stream_ff     <= '0;
            msgword_ff    <= '0;
            length_ff     <= '0;
            term_good_ff  <= 1'b0;
         end else begin
            byte_count_ff <= byte_count_in;
            crc_ff        <= crc_in;
            magic_ff      <= magic_in;
            checksum_ff   <= checksum_in;
            stream_ff     <= stream_in;
            msgword_ff    <= msgword_in;
            length_ff     <= length_in;
            term_good_ff  <= term_good_in;
         end
      end
   end

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.in_last |=> byte_count_ff == '0 && crc_ff == '1)
      else $error("frame state not cleared after last byte");

   a_payload_needs_magic: assert property (@(posedge clock) disable iff (reset)
      q_push && q_entry.kind == KIND_PAYLOAD |-> magic_ff == cfg.magic_word && !in_header)
      else $error("payload byte passed without matching magic");

endmodule

>>> sv/cpdc_queue.sv
module cpdc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cpdc_pkg::entry_type push_entry,
   output logic                push_ready,
   input  logic                pop,
   output logic                pop_valid,
   output cpdc_pkg::entry_type pop_entry
);
   import cpdc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = mem[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count lost a push");

endmodule

>>> sv/cpdc_back.sv
module cpdc_back (
   input  logic                clock,
   input  logic                reset,
   input  cpdc_pkg::cfg_type   cfg,
   input  logic                q_valid,
   input  cpdc_pkg::entry_type q_entry,
   output logic                q_pop,
   cpdc_rsp_if.source          rsp_bus
);
   import cpdc_pkg::*;

   logic              valid_ff;
   logic              kind_ff;
   logic [7:0]        data_ff;
   status_type        status_ff;
   logic [WORD_W-1:0] stream_ff;
   logic [WORD_W-1:0] msg_ff, msg_in;
   logic              reply_ff, reply_in;
   logic [WORD_W-1:0] length_ff;
   logic [WORD_W-1:0] mask;

   assign q_pop = q_valid && (!valid_ff || rsp_bus.ready);

   // split the reply flag off the message id word
   always_comb begin
      mask     = WORD_W'(1) << cfg.reply_bit_pos;
      msg_in   = q_entry.msgword & ~mask;
      reply_in = (q_entry.msgword & mask) != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || rsp_bus.ready) begin
         valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff   <= q_entry.kind;
         data_ff   <= q_entry.data;
         status_ff <= q_entry.status;
         stream_ff <= q_entry.stream;
         msg_ff    <= msg_in;
         reply_ff  <= reply_in;
         length_ff <= q_entry.length;
      end
   end

   assign rsp_bus.valid           = valid_ff;
   assign rsp_bus.out_kind        = kind_ff;
   assign rsp_bus.out_byte        = data_ff;
   assign rsp_bus.out_status      = status_ff;
   assign rsp_bus.out_stream_id   = stream_ff;
   assign rsp_bus.out_message_id  = msg_ff;
   assign rsp_bus.out_is_reply    = reply_ff;
   assign rsp_bus.out_payload_len = length_ff;
   assign rsp_bus.out_last        = kind_ff == KIND_STATUS;

endmodule

>>> sv/crc32_packet_deframer_checker.sv
// Framed packet deframer and checker. Bytes of a received buffer arrive as
// requests, one per cycle at full rate while the queue has room, with in_last
// on the final byte. The first 20 bytes are a big-endian header (magic,
// checksum, stream id, message id, payload length); payload bytes that follow
// are passed on as results as long as the magic matches magic_word. A
// reflected CRC-32 runs over header (checksum bytes taken as zero) and payload
// in a byte-wide XOR network in the front end. The last byte yields one status
// result with the first failure found: short header, bad magic, truncated,
// bad terminator, bad CRC. Bytes after the terminator give no result. A result
// passes through the queue and the output register before it is valid on the
// response port; the two-entry queue and the output register let requests
// keep flowing while a response waits. Write csr registers only while no
// request is in flight.
module crc32_packet_deframer_checker (
   input  logic     clock,
   input  logic     reset,
   cpdc_req_if.sink  req_bus,
   cpdc_rsp_if.source rsp_bus,
   cpdc_csr_if.sink  csr_bus
);
   import cpdc_pkg::*;

   cfg_type   cfg_ff;
   logic      push;
   logic      push_ready;
   entry_type push_entry;
   logic      pop;
   logic      pop_valid;
   entry_type pop_entry;

   // configuration writes are always taken; unknown indexes drop
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_word      <= '0;
         cfg_ff.terminator_byte <= '0;
         cfg_ff.reply_bit_pos   <= 5'd31;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_MAGIC:      cfg_ff.magic_word      <= csr_bus.data;
            CSR_TERMINATOR: cfg_ff.terminator_byte <= csr_bus.data[7:0];
            CSR_REPLY_POS:  cfg_ff.reply_bit_pos   <= csr_bus.data[4:0];
            default:        ;
         endcase
      end
   end

   // front end: track frame position, header words, CRC; classify each request
   cpdc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .cfg     (cfg_ff),
      .q_ready (push_ready),
      .q_push  (push),
      .q_entry (push_entry)
   );

   // hold finished results between front and back
   cpdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // back end: split the reply bit and drive the response register
   cpdc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (pop_valid),
      .q_entry (pop_entry),
      .q_pop   (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

>>> bench/crc32_packet_deframer_checker_tb.sv
`timescale 1ns / 100ps

module crc32_packet_deframer_checker_tb;
   import cpdc_pkg::*;

   // One result as the response port shows it; payload bytes leave the
   // header fields at zero.
   typedef struct packed {
      logic              kind;
      logic [7:0]        data;
      status_type        status;
      logic [WORD_W-1:0] stream;
      logic [WORD_W-1:0] msg_id;
      logic              reply;
      logic [WORD_W-1:0] length;
      logic              last_flag;
   } frame_result_type;

   logic clock;
   logic reset;

   cpdc_req_if req_bus ();
   cpdc_rsp_if rsp_bus ();
   cpdc_csr_if csr_bus ();

   crc32_packet_deframer_checker i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Register copies, updated when the csr write is accepted.
   logic [WORD_W-1:0] cfg_magic;
   logic [7:0]        cfg_term;
   logic [4:0]        cfg_reply_pos;

   // Frame tracking, one copy per buffer in progress.
   logic [COUNT_W-1:0] rx_count;
   logic [WORD_W-1:0]  run_crc;
   logic [WORD_W-1:0]  got_magic;
   logic [WORD_W-1:0]  got_checksum;
   logic [WORD_W-1:0]  got_stream;
   logic [WORD_W-1:0]  got_msgword;
   logic [WORD_W-1:0]  got_length;
   logic               term_seen_ok;

   frame_result_type due_results[$];
   logic [7:0]       frame_bytes[$];

   int mismatch_count;
   int sender_idle_pct;
   int receiver_stall_pct;

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Hard stop far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Reflected CRC-32, one byte, bit by bit.
   function automatic logic [WORD_W-1:0] crc32_next(input logic [WORD_W-1:0] crc,
                                                    input logic [7:0] b);
      logic [WORD_W-1:0] c;
      c = crc ^ WORD_W'(b);
      repeat (8) c = (c >> 1) ^ (32'hEDB8_8320 & {WORD_W{c[0]}});
      return c;
   endfunction

   function automatic void clear_frame_state();
      rx_count     = '0;
      run_crc      = '1;
      got_magic    = '0;
      got_checksum = '0;
      got_stream   = '0;
      got_msgword  = '0;
      got_length   = '0;
      term_seen_ok = 1'b0;
   endfunction

   // Advance the frame tracking by one accepted byte; report whether it
   // produces a result and what that result must be.
   function automatic void predict_deframe(input logic [7:0] b, input logic last,
                                           output logic produced,
                                           output frame_result_type res);
      logic [COUNT_W:0]  pos;
      logic [COUNT_W:0]  pay_end;
      logic [WORD_W-1:0] mask;
      logic              emit;
      pos      = {1'b0, rx_count};
      pay_end  = (COUNT_W+1)'(HEADER_BYTES) + got_length;
      emit     = 1'b0;
      produced = 1'b0;
      res      = '0;
      if (pos < HEADER_BYTES) begin
         if (pos < CHECKSUM_OFS) begin
            got_magic = {got_magic[23:0], b};
            run_crc   = crc32_next(run_crc, b);
         end else if (pos < STREAM_OFS) begin
            // checksum bytes enter the CRC as zero
            got_checksum = {got_checksum[23:0], b};
            run_crc      = crc32_next(run_crc, 8'h00);
         end else if (pos < MSGWORD_OFS) begin
            got_stream = {got_stream[23:0], b};
            run_crc    = crc32_next(run_crc, b);
         end else if (pos < LENGTH_OFS) begin
            got_msgword = {got_msgword[23:0], b};
            run_crc     = crc32_next(run_crc, b);
         end else begin
            got_length = {got_length[23:0], b};
            run_crc    = crc32_next(run_crc, b);
         end
      end else if (pos < pay_end) begin
         run_crc = crc32_next(run_crc, b);
         emit    = (got_magic == cfg_magic);
      end else if (pos == pay_end) begin
         term_seen_ok = (b == cfg_term);
      end
      if (rx_count != '1) rx_count = rx_count + 1'b1;

      if (!last) begin
         if (emit) begin
            produced = 1'b1;
            res.kind = KIND_PAYLOAD;
            res.data = b;
         end
         return;
      end

      produced      = 1'b1;
      res.kind      = KIND_STATUS;
      res.last_flag = 1'b1;
      if (rx_count < HEADER_BYTES) begin
         res.status = STATUS_SHORT;
      end else begin
         mask = WORD_W'(1) << cfg_reply_pos;
         if (got_magic != cfg_magic)
            res.status = STATUS_BAD_MAGIC;
         else if ({1'b0, rx_count} < pay_end + 1'b1)
            res.status = STATUS_SHORT;
         else if (!term_seen_ok)
            res.status = STATUS_BAD_TERM;
         else if (~run_crc != got_checksum)
            res.status = STATUS_BAD_CRC;
         else
            res.status = STATUS_OK;
         res.stream = got_stream;
         res.msg_id = got_msgword & ~mask;
         res.reply  = |(got_msgword & mask);
         res.length = got_length;
      end
      clear_frame_state();
   endfunction

   // Random backpressure on the response port; ready changes on the falling edge.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Compare every accepted response with the oldest expectation.
   always @(posedge clock) begin : check_results
      frame_result_type seen;
      frame_result_type want;
      logic             bad;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.kind      = rsp_bus.out_kind;
         seen.data      = rsp_bus.out_byte;
         seen.status    = rsp_bus.out_status;
         seen.stream    = rsp_bus.out_stream_id;
         seen.msg_id    = rsp_bus.out_message_id;
         seen.reply     = rsp_bus.out_is_reply;
         seen.length    = rsp_bus.out_payload_len;
         seen.last_flag = rsp_bus.out_last;
         if (due_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected response %p", $realtime, seen);
         end else begin
            want = due_results.pop_front();
            bad  = (seen.kind !== want.kind) || (seen.data !== want.data)
                || (seen.status !== want.status) || (seen.stream !== want.stream)
                || (seen.msg_id !== want.msg_id) || (seen.reply !== want.reply)
                || (seen.length !== want.length) || (seen.last_flag !== want.last_flag);
            if (bad) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response mismatch\n  expected %p\n  actual   %p",
                           $realtime, want, seen);
            end
         end
      end
   end

   // Send one byte request; entered and left at a falling edge, valid held
   // high unless the sender idles.
   task automatic send_request(input logic [7:0] b, input logic last);
      frame_result_type res;
      logic             produced;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.in_last <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_deframe(b, last, produced, res);
      if (produced) due_results.push_back(res);
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_request(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // Drop valid, drain every expected result, then let trailing bytes that
   // give no result settle.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Write all three registers back to back; valid stays high across them.
   task automatic write_config(input logic [WORD_W-1:0] magic, input logic [7:0] term,
                               input logic [4:0] pos);
      csr_index_type idx;
      for (int i = 0; i < 3; i++) begin
         idx = csr_index_type'(i);
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx;
         case (idx)
            CSR_MAGIC:      csr_bus.data <= magic;
            CSR_TERMINATOR: csr_bus.data <= WORD_W'(term);
            default:        csr_bus.data <= WORD_W'(pos);
         endcase
         do @(posedge clock); while (csr_bus.ready !== 1'b1);
         case (idx)
            CSR_MAGIC:      cfg_magic     = magic;
            CSR_TERMINATOR: cfg_term      = term;
            default:        cfg_reply_pos = pos;
         endcase
         @(negedge clock);
      end
      csr_bus.valid <= 1'b0;
   endtask

   // Build a buffer: header, pay_n payload bytes, terminator, trail_n extra
   // bytes. The checksum covers header and present payload, optionally spoiled.
   task automatic build_frame(input logic [WORD_W-1:0] magic, input logic [WORD_W-1:0] stream,
                              input logic [WORD_W-1:0] msg, input logic [WORD_W-1:0] len_field,
                              input int pay_n, input logic [7:0] term, input int trail_n,
                              input bit crc_err);
      logic [WORD_W-1:0] crc;
      logic [WORD_W-1:0] words[5];
      words = '{magic, 32'd0, stream, msg, len_field};
      frame_bytes.delete();
      foreach (words[w])
         for (int k = 3; k >= 0; k--) frame_bytes.push_back(words[w][8*k +: 8]);
      repeat (pay_n) frame_bytes.push_back(8'($urandom));
      crc = '1;
      foreach (frame_bytes[i]) crc = crc32_next(crc, frame_bytes[i]);
      crc = ~crc;
      if (crc_err) crc ^= WORD_W'(1) << $urandom_range(31);
      for (int k = 0; k < 4; k++) frame_bytes[CHECKSUM_OFS + k] = crc[8*(3-k) +: 8];
      frame_bytes.push_back(term);
      repeat (trail_n) frame_bytes.push_back(8'($urandom));
   endtask

   task automatic random_bytes(input int n);
      frame_bytes.delete();
      repeat (n) frame_bytes.push_back(8'($urandom));
   endtask

   // Reset register values: magic 0, terminator 0, reply flag on bit 31.
   task automatic test_default_registers();
      build_frame(32'd0, 32'h1234_5678, 32'h8000_0001, 32'd0, 0, 8'h00, 0, 0);
      send_frame();
      build_frame(32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd2, 2, 8'h00, 0, 0);
      send_frame();
   endtask

   // Buffers ending before the header is complete: one byte, nineteen bytes.
   task automatic test_short_header();
      random_bytes(1);
      send_frame();
      random_bytes(HEADER_BYTES - 1);
      send_frame();
   endtask

   // Extreme registers; good frames with empty and short payloads, bytes
   // past the terminator, and the reply flag in bit 0.
   task automatic test_good_frames();
      wait_idle();
      write_config(32'hFFFF_FFFF, 8'hFF, 5'd0);
      build_frame(32'hFFFF_FFFF, 32'd0, 32'h0000_0001, 32'd0, 0, 8'hFF, 0, 0);
      send_frame();
      build_frame(32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'hFFFF_FFFE, 32'd3, 3, 8'hFF, 2, 0);
      send_frame();
   endtask

   // Magic mismatch: payload is held back and the status names the magic.
   task automatic test_bad_magic();
      build_frame(32'h7FFF_FFFF, 32'h0BAD_0BAD, 32'h1, 32'd2, 2, 8'hFF, 0, 0);
      send_frame();
   endtask

   // Last byte inside the payload, a buffer that stops before its terminator,
   // and a huge length field.
   task automatic test_truncation();
      build_frame(32'hFFFF_FFFF, 32'h1, 32'h2, 32'd4, 4, 8'hFF, 0, 0);
      frame_bytes = frame_bytes[0 : HEADER_BYTES + 1];
      send_frame();
      build_frame(32'hFFFF_FFFF, 32'h3, 32'h4, 32'd2, 2, 8'hFF, 0, 0);
      void'(frame_bytes.pop_back());
      send_frame();
      build_frame(32'hFFFF_FFFF, 32'h5, 32'h6, 32'hFFFF_FFFF, 1, 8'hFF, 0, 0);
      send_frame();
   endtask

   // Wrong terminator, then a spoiled checksum.
   task automatic test_terminator_and_crc();
      build_frame(32'hFFFF_FFFF, 32'h7, 32'h8, 32'd1, 1, 8'h00, 0, 0);
      send_frame();
      build_frame(32'hFFFF_FFFF, 32'h9, 32'hA, 32'd1, 1, 8'hFF, 1, 1);
      send_frame();
   endtask

   // Random buffers: mostly well formed, the rest faulty or plain noise.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [WORD_W-1:0] magic, input logic [7:0] term,
                                      input logic [4:0] pos, input int byte_budget);
      int          sent;
      int          pick;
      int          len;
      int          keep;
      logic [31:0] len_field;
      wait_idle();
      write_config(magic, term, pos);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < byte_budget) begin
         pick = $urandom_range(99);
         len  = $urandom_range(0, 12);
         if (pick < 60) begin
            build_frame(cfg_magic, $urandom, $urandom, len, len, cfg_term,
                        ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0, 0);
         end else if (pick < 68) begin
            build_frame(cfg_magic, $urandom, $urandom, len, len, cfg_term, 0, 1);
         end else if (pick < 75) begin
            build_frame(cfg_magic, $urandom, $urandom, len, len,
                        cfg_term ^ 8'($urandom_range(1, 255)), 0, 0);
         end else if (pick < 82) begin
            build_frame(cfg_magic ^ WORD_W'($urandom_range(1, 32'hFFFF_FFFF)),
                        $urandom, $urandom, len, len, cfg_term, 0, 0);
         end else if (pick < 90) begin
            // cut right after the header or inside the payload, before the terminator
            len_field = $urandom_range(1) ? $urandom : $urandom_range(1, 16);
            len = (len_field > 16) ? 16 : len_field;
            build_frame(cfg_magic, $urandom, $urandom, len_field, len, cfg_term, 0, 0);
            keep = $urandom_range(HEADER_BYTES, HEADER_BYTES + len);
            frame_bytes = frame_bytes[0 : keep - 1];
         end else if (pick < 95) begin
            random_bytes($urandom_range(1, HEADER_BYTES - 1));
         end else begin
            random_bytes($urandom_range(1, 40));
         end
         sent += frame_bytes.size();
         send_frame();
      end
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   initial begin
      // drive every input known from time zero
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.in_byte    = '0;
      req_bus.in_last    = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_MAGIC;
      csr_bus.data       = '0;
      rsp_bus.ready      = 1'b0;
      mismatch_count     = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      cfg_magic          = '0;
      cfg_term           = '0;
      cfg_reply_pos      = 5'd31;
      clear_frame_state();

      // hold reset, then release it on a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_default_registers();
      test_short_header();
      test_good_frames();
      test_bad_magic();
      test_truncation();
      test_terminator_and_crc();

      test_random_traffic(0, 0, $urandom, 8'($urandom), 5'($urandom), 260);
      test_random_traffic(56, 0, 32'd0, 8'h00, 5'd31, 260);
      test_random_traffic(0, 56, 32'hFFFF_FFFF, 8'hFF, 5'd0, 260);
      test_random_traffic(6, 6, $urandom, 8'($urandom), 5'($urandom), 260);

      // drain, then allow for the pipeline before judging
      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
